// ----- src/lcfb_pkg.sv -----
`default_nettype none

package lcfb_pkg;

   localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
   localparam int unsigned MaxBeats = 6;
   localparam int unsigned BeatCountWidth = $clog2(MaxBeats + 1);

   typedef logic [BeatCountWidth-1:0] beat_count_type;
   typedef logic [7:0] byte_type;
   typedef logic [31:0] crc_type;
   typedef logic [15:0] length_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   localparam beat_count_type BeatsHeader      = beat_count_type'(2);
   localparam beat_count_type BeatsHeaderCrc   = beat_count_type'(6);
   localparam beat_count_type BeatsData        = beat_count_type'(1);
   localparam beat_count_type BeatsDataCrc     = beat_count_type'(5);

   function automatic crc_type crc_feed(input crc_type rem_value, input byte_type data_value);
      crc_type r;
      r = rem_value ^ {data_value, 24'h00_0000};
      for (int k = 0; k < 8; k++) begin
         if (r[31]) begin
            r = {r[30:0], 1'b0} ^ CrcPoly;
         end else begin
            r = {r[30:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/lcfb_req_if.sv -----
`default_nettype none

interface lcfb_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] payload_length;
   logic [7:0]  data_byte;

   modport source (output valid, output command, output payload_length, output data_byte,
                   input ready);
   modport sink (input valid, input command, input payload_length, input data_byte,
                 output ready);
endinterface

`default_nettype wire

// ----- src/lcfb_rsp_if.sv -----
`default_nettype none

interface lcfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- src/length_crc32_frame_builder_unit.sv -----
// Channel   Direction  Beat contents
// req_chan  in         command, payload_length, data_byte
// rsp_chan  out        frame_byte, frame_last
//
// An accepted request is decoded in the same cycle and up to six output bytes are loaded
// into a burst register, from which one byte leaves per cycle while the output is ready.
// A request is taken every cycle while each burst holds one byte and the output is ready;
// a start or the last payload byte fills the output with two, five or six bytes.
// Reset is synchronous and clears the frame state and the burst count.
// While the output stalls on its last byte, a new request waits for that byte to leave.
`default_nettype none

module length_crc32_frame_builder_unit (
   input wire logic   clock,
   input wire logic   reset,
   lcfb_req_if.sink   req_chan,
   lcfb_rsp_if.source rsp_chan
);

   lcfb_pkg::byte_type       burst_ff [lcfb_pkg::MaxBeats];
   lcfb_pkg::byte_type       burst_in [lcfb_pkg::MaxBeats];
   lcfb_pkg::beat_count_type beats_ff, beats_in;
   logic                     last_ff, last_in;
   lcfb_pkg::crc_type        crc_ff, crc_in;
   lcfb_pkg::length_type     remaining_ff, remaining_in;
   logic                     open_ff, open_in;

   logic                     req_accept;
   logic                     rsp_accept;
   lcfb_pkg::crc_type        crc_header;
   lcfb_pkg::crc_type        crc_data;
   lcfb_pkg::length_type     remaining_dec;

   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (beats_ff == '0) || ((beats_ff == lcfb_pkg::BeatsData) && rsp_chan.ready);
   assign req_accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = (beats_ff != '0);
   assign rsp_chan.frame_byte = burst_ff[0];
   assign rsp_chan.frame_last = last_ff && (beats_ff == lcfb_pkg::BeatsData);

   assign crc_header = lcfb_pkg::crc_feed(lcfb_pkg::crc_feed('0, req_chan.payload_length[15:8]),
                                          req_chan.payload_length[7:0]);
   assign crc_data = lcfb_pkg::crc_feed(crc_ff, req_chan.data_byte);
   assign remaining_dec = remaining_ff - 16'd1;

   always_comb begin
      burst_in = burst_ff;
      beats_in = beats_ff;
      last_in = last_ff;
      crc_in = crc_ff;
      remaining_in = remaining_ff;
      open_in = open_ff;

      if (rsp_accept) begin
         for (int i = 0; i < lcfb_pkg::MaxBeats - 1; i++) begin
            burst_in[i] = burst_ff[i+1];
         end
         beats_in = beats_ff - lcfb_pkg::BeatsData;
      end

      if (req_accept) begin
         case (req_chan.command)
            lcfb_pkg::CMD_START: begin
               burst_in[0] = req_chan.payload_length[15:8];
               burst_in[1] = req_chan.payload_length[7:0];
               burst_in[2] = crc_header[31:24];
               burst_in[3] = crc_header[23:16];
               burst_in[4] = crc_header[15:8];
               burst_in[5] = crc_header[7:0];
               crc_in = crc_header;
               remaining_in = req_chan.payload_length;
               if (req_chan.payload_length == '0) begin
                  beats_in = lcfb_pkg::BeatsHeaderCrc;
                  last_in = 1'b1;
                  open_in = 1'b0;
               end else begin
                  beats_in = lcfb_pkg::BeatsHeader;
                  last_in = 1'b0;
                  open_in = 1'b1;
               end
            end
            lcfb_pkg::CMD_DATA: begin
               if (open_ff) begin
                  burst_in[0] = req_chan.data_byte;
                  burst_in[1] = crc_data[31:24];
                  burst_in[2] = crc_data[23:16];
                  burst_in[3] = crc_data[15:8];
                  burst_in[4] = crc_data[7:0];
                  crc_in = crc_data;
                  remaining_in = remaining_dec;
                  if (remaining_dec == '0) begin
                     beats_in = lcfb_pkg::BeatsDataCrc;
                     last_in = 1'b1;
                     open_in = 1'b0;
                  end else begin
                     beats_in = lcfb_pkg::BeatsData;
                     last_in = 1'b0;
                  end
               end
            end
            default: begin
               open_in = open_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= '0;
         last_ff <= 1'b0;
         crc_ff <= '0;
         remaining_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         beats_ff <= beats_in;
         last_ff <= last_in;
         crc_ff <= crc_in;
         remaining_ff <= remaining_in;
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

endmodule

`default_nettype wire

// ----- src/lcfb_checker.sv -----
`default_nettype none

module lcfb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_command,
   input wire logic [15:0] req_payload_length,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_frame_byte,
   input wire logic        rsp_frame_last
);

   // A start beat puts the high length byte at the head of the output in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == lcfb_pkg::CMD_START)) |=>
         (rsp_valid && !rsp_frame_last && (rsp_frame_byte == $past(req_payload_length[15:8]))))
      else $error("start beat did not produce the length header");

   // No request may be taken while the output holds a byte that cannot leave.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while output stalled");

   // A stalled output beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_last)))
      else $error("stalled output beat changed");

   // After the last byte of a frame leaves, only a new request can refill the output.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_frame_last && !(req_valid && req_ready)) |=> !rsp_valid)
      else $error("output continued after the last frame byte");

endmodule

bind length_crc32_frame_builder_unit lcfb_checker u_lcfb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_command        (req_chan.command),
   .req_payload_length (req_chan.payload_length),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_frame_byte     (rsp_chan.frame_byte),
   .rsp_frame_last     (rsp_chan.frame_last)
);

`default_nettype wire

// ----- tb/length_crc32_frame_builder_unit_test.sv -----
`timescale 1ns / 1ps

module length_crc32_frame_builder_unit_test;

   localparam int CycleLimit = 200000;
   localparam int LongStallCycles = 400;
   localparam int RandomItemTarget = 360;

   typedef struct {
      lcfb_pkg::cmd_type    command;
      lcfb_pkg::length_type payload_length;
      lcfb_pkg::byte_type   data_byte;
   } frame_request_type;

   typedef struct {
      lcfb_pkg::byte_type value;
      logic               last;
   } frame_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcfb_req_if req_bus ();
   lcfb_rsp_if rsp_bus ();

   length_crc32_frame_builder_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   frame_request_type request_queue[$];
   frame_beat_type    pending_frame_bytes[$];

   lcfb_pkg::crc_type    frame_crc = '0;
   lcfb_pkg::length_type frame_left = '0;
   logic                 frame_is_open = 1'b0;

   int total_requests = 0;
   int accepted_count = 0;
   int phase_one_end = 0;
   int phase_two_end = 0;
   int cycle_count = 0;
   int stall_left = 0;
   logic stall_done = 1'b0;

   int mismatch_count = 0;
   int beats_checked = 0;
   int frames_closed = 0;
   int frames_abandoned = 0;
   int ignored_count = 0;

   frame_request_type next_request;
   frame_request_type taken_request;

   function automatic lcfb_pkg::crc_type crc_shift_byte(input lcfb_pkg::crc_type crc_in,
                                                        input lcfb_pkg::byte_type data_in);
      lcfb_pkg::crc_type c;
      logic              feedback;
      c = crc_in;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[31] ^ data_in[i];
         c = {c[30:0], 1'b0};
         if (feedback) begin
            c = c ^ lcfb_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic int traffic_phase();
      if (accepted_count < phase_one_end) begin
         return 0;
      end else if (accepted_count < phase_two_end) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic int send_idle_percent();
      case (traffic_phase())
         0: return 6;
         1: return 82;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_percent();
      case (traffic_phase())
         0: return 82;
         1: return 6;
         default: return 0;
      endcase
   endfunction

   task automatic push_start(input lcfb_pkg::length_type len);
      frame_request_type r;
      r.command = lcfb_pkg::CMD_START;
      r.payload_length = len;
      r.data_byte = lcfb_pkg::byte_type'($urandom_range(0, 255));
      request_queue.push_back(r);
   endtask

   task automatic push_data(input lcfb_pkg::byte_type value);
      frame_request_type r;
      r.command = lcfb_pkg::CMD_DATA;
      r.payload_length = lcfb_pkg::length_type'($urandom_range(0, 65535));
      r.data_byte = value;
      request_queue.push_back(r);
   endtask

   task automatic queue_frame_byte(input lcfb_pkg::byte_type value, input logic last);
      frame_beat_type b;
      b.value = value;
      b.last = last;
      pending_frame_bytes.push_back(b);
   endtask

   task automatic queue_crc_bytes();
      queue_frame_byte(frame_crc[31:24], 1'b0);
      queue_frame_byte(frame_crc[23:16], 1'b0);
      queue_frame_byte(frame_crc[15:8], 1'b0);
      queue_frame_byte(frame_crc[7:0], 1'b1);
   endtask

   task automatic predict_frame(input frame_request_type req);
      if (req.command == lcfb_pkg::CMD_START) begin
         if (frame_is_open) begin
            frames_abandoned++;
         end
         frame_crc = crc_shift_byte(lcfb_pkg::crc_type'(0), req.payload_length[15:8]);
         frame_crc = crc_shift_byte(frame_crc, req.payload_length[7:0]);
         queue_frame_byte(req.payload_length[15:8], 1'b0);
         queue_frame_byte(req.payload_length[7:0], 1'b0);
         if (req.payload_length == '0) begin
            queue_crc_bytes();
            frame_is_open = 1'b0;
            frame_left = '0;
         end else begin
            frame_is_open = 1'b1;
            frame_left = req.payload_length;
         end
      end else if (!frame_is_open) begin
         ignored_count++;
      end else begin
         frame_crc = crc_shift_byte(frame_crc, req.data_byte);
         queue_frame_byte(req.data_byte, 1'b0);
         frame_left = frame_left - 16'd1;
         if (frame_left == '0) begin
            queue_crc_bytes();
            frame_is_open = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_beat(input lcfb_pkg::byte_type value, input logic last);
      frame_beat_type want;
      beats_checked++;
      if (pending_frame_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected beat %02h last %0b", value, last));
      end else begin
         want = pending_frame_bytes.pop_front();
         if (value !== want.value) begin
            report_mismatch($sformatf("frame_byte %02h, wanted %02h", value, want.value));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("frame_last %0b, wanted %0b", last, want.last));
         end
         if (want.last) begin
            frames_closed++;
         end
      end
   endtask

   task automatic queue_random_requests(input int target);
      int counted;
      int len;
      int cut;
      int pick;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 6) : $urandom_range(7, 24);
            push_start(lcfb_pkg::length_type'(len));
            for (int i = 0; i < len; i++) begin
               push_data(lcfb_pkg::byte_type'($urandom_range(0, 255)));
            end
            counted += len + 1;
         end else if (pick < 87) begin
            len = $urandom_range(2, 65535);
            cut = $urandom_range(0, 5);
            push_start(lcfb_pkg::length_type'(len));
            for (int i = 0; i < cut; i++) begin
               push_data(lcfb_pkg::byte_type'($urandom_range(0, 255)));
            end
            counted += cut + 1;
         end else begin
            cut = $urandom_range(1, 3);
            for (int i = 0; i < cut; i++) begin
               push_data(lcfb_pkg::byte_type'($urandom_range(0, 255)));
            end
            counted += cut;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("length_crc32_frame_builder_unit_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.command <= 1'b0;
         req_bus.payload_length <= '0;
         req_bus.data_byte <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken_request.command = lcfb_pkg::cmd_type'(req_bus.command);
            taken_request.payload_length = req_bus.payload_length;
            taken_request.data_byte = req_bus.data_byte;
            predict_frame(taken_request);
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_percent()) begin
               next_request = request_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.command <= next_request.command;
               req_bus.payload_length <= next_request.payload_length;
               req_bus.data_byte <= next_request.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && accepted_count >= phase_two_end + 10) begin
         stall_left <= LongStallCycles;
         stall_done <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_beat(rsp_bus.frame_byte, rsp_bus.frame_last);
         end
         rsp_bus.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_percent());
      end
   end

   initial begin
      // A stray data beat before any frame, then the length extremes, abandoned frames and more stray data beats.
      push_data(8'hA5);
      push_start(16'h0000);
      push_start(16'h0001);
      push_data(8'hFF);
      push_start(16'h0003);
      push_data(8'h00);
      push_data(8'hFF);
      push_data(8'h5A);
      push_data(8'h3C);
      push_start(16'hFFFF);
      push_data(8'h80);
      push_data(8'h01);
      push_start(16'h8001);
      push_data(8'h7F);
      push_start(16'h0002);
      push_data(8'hC3);
      push_data(8'h24);
      push_start(16'h0000);
      push_data(8'h99);
      queue_random_requests(RandomItemTarget);

      total_requests = request_queue.size();
      phase_one_end = total_requests / 3;
      phase_two_end = (2 * total_requests) / 3;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests) begin
         @(posedge clock);
      end
      while (pending_frame_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("%0d requests accepted, %0d ignored outside a frame, %0d frames abandoned",
               total_requests, ignored_count, frames_abandoned);
      $display("%0d beats checked over %0d completed frames, one long output stall",
               beats_checked, frames_closed);
      if (mismatch_count == 0) begin
         $display("length_crc32_frame_builder_unit_test OK");
      end else begin
         $display("length_crc32_frame_builder_unit_test NOT OK");
      end
      $finish;
   end

endmodule
